// ===== src/mrfp_pkg.sv =====
`timescale 1ns / 1ps

package mrfp_pkg;

   localparam int ByteW   = 8;
   localparam int PosW    = 32;
   localparam int CntW    = 4;
   localparam int CsrIdxW = 2;

   localparam logic [CntW-1:0] SUM_LEN = 4'd8;
   localparam logic [2:0]      CMD_SLOT = 3'd3;

   localparam logic [ByteW-1:0] RST_REPLY_ADDRESS    = 8'h02;
   localparam logic [ByteW-1:0] RST_MODULE_ADDRESS   = 8'h01;
   localparam logic [ByteW-1:0] RST_OK_STATUS        = 8'h64;
   localparam logic [ByteW-1:0] RST_POSITION_COMMAND = 8'h06;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_REPLY_ADDRESS    = 2'd0,
      CSR_MODULE_ADDRESS   = 2'd1,
      CSR_OK_STATUS        = 2'd2,
      CSR_POSITION_COMMAND = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_WAIT_ADDR   = 3'd0,
      ST_WAIT_MOD    = 3'd1,
      ST_WAIT_STATUS = 3'd2,
      ST_COLLECT     = 3'd3,
      ST_CHECKSUM    = 3'd4
   } parse_state_type;

   typedef struct packed {
      logic [ByteW-1:0] reply_address;
      logic [ByteW-1:0] module_address;
      logic [ByteW-1:0] ok_status;
      logic [ByteW-1:0] position_command;
   } cfg_type;

   typedef struct packed {
      logic                   frame_end;
      logic                   checksum_good;
      logic                   position_valid;
      logic [ByteW-1:0]       reply_command;
      logic signed [PosW-1:0] position;
   } rsp_type;

endpackage

// ===== src/mrfp_parser.sv =====
`timescale 1ns / 1ps

module mrfp_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [mrfp_pkg::ByteW-1:0]        rx_byte,
   input  mrfp_pkg::cfg_type                 cfg,
   output mrfp_pkg::rsp_type                 rsp
);

   mrfp_pkg::parse_state_type          state_ff, state_in;
   logic [mrfp_pkg::CntW-1:0]          count_ff, count_in;
   logic [mrfp_pkg::ByteW-1:0]         sum_ff, sum_in;
   logic [mrfp_pkg::ByteW-1:0]         cmd_ff, cmd_in;
   logic [mrfp_pkg::PosW-1:0]          value_ff, value_in;
   logic signed [mrfp_pkg::PosW-1:0]   position_ff, position_in;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      cmd_in      = cmd_ff;
      value_in    = value_ff;
      position_in = position_ff;
      rsp         = '0;
      case (state_ff)
         mrfp_pkg::ST_WAIT_ADDR: begin
            count_in = '0;
            if (rx_byte == cfg.reply_address) begin
               sum_in   = rx_byte;
               count_in = 4'd1;
               state_in = mrfp_pkg::ST_WAIT_MOD;
            end
         end
         mrfp_pkg::ST_WAIT_MOD: begin
            if (rx_byte == cfg.module_address) begin
               sum_in   = sum_ff + rx_byte;
               count_in = 4'd2;
               state_in = mrfp_pkg::ST_WAIT_STATUS;
            end else begin
               state_in = mrfp_pkg::ST_WAIT_ADDR;
            end
         end
         mrfp_pkg::ST_WAIT_STATUS: begin
            if (rx_byte == cfg.ok_status) begin
               sum_in   = sum_ff + rx_byte;
               count_in = 4'd3;
               state_in = mrfp_pkg::ST_COLLECT;
            end else begin
               state_in = mrfp_pkg::ST_WAIT_ADDR;
            end
         end
         mrfp_pkg::ST_COLLECT: begin
            sum_in = sum_ff + rx_byte;
            if (count_ff[2:0] == mrfp_pkg::CMD_SLOT) begin
               cmd_in = rx_byte;
            end else begin
               value_in = {value_ff[mrfp_pkg::PosW-mrfp_pkg::ByteW-1:0], rx_byte};
            end
            count_in = count_ff + 4'd1;
            if (count_in >= mrfp_pkg::SUM_LEN) begin
               state_in = mrfp_pkg::ST_CHECKSUM;
            end
         end
         mrfp_pkg::ST_CHECKSUM: begin
            rsp.frame_end     = 1'b1;
            rsp.reply_command = cmd_ff;
            if (rx_byte == sum_ff) begin
               rsp.checksum_good = 1'b1;
               if (cmd_ff == cfg.position_command) begin
                  position_in        = value_ff;
                  rsp.position_valid = 1'b1;
               end
            end
            count_in = '0;
            state_in = mrfp_pkg::ST_WAIT_ADDR;
         end
         default: begin
            count_in = '0;
            state_in = mrfp_pkg::ST_WAIT_ADDR;
         end
      endcase
      rsp.position = position_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= mrfp_pkg::ST_WAIT_ADDR;
         count_ff    <= '0;
         position_ff <= '0;
      end else if (advance) begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         position_ff <= position_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff   <= sum_in;
         cmd_ff   <= cmd_in;
         value_ff <= value_in;
      end
   end

endmodule

// ===== src/motor_reply_frame_parser.sv =====
`timescale 1ns / 1ps

// Reply frame parser: each request beat carries one received byte and yields
// exactly one response beat, one beat per clock while rsp_tready allows, via
// two registers (input register, then result register). The checksum is kept
// as a running sum, so the per-byte path is one 8-bit add and compare. tlast
// marks the checksum byte of a frame; tuser flags checksum match and position
// update. Users must write csr regs only while the block is idle (not enforced).
module motor_reply_frame_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] rx_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [39:0]                         rsp_tdata,   // [7:0] reply_command, [39:8] position
   output logic                                rsp_tlast,   // frame_end
   output logic [1:0]                          rsp_tuser,   // [0] checksum_good, [1] position_valid
   input  logic                                csr_write_enable,
   input  logic [mrfp_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [mrfp_pkg::ByteW-1:0]          csr_wdata
);

   logic                          in_valid_ff, in_valid_in;
   logic [mrfp_pkg::ByteW-1:0]    in_byte_ff;
   logic                          out_valid_ff, out_valid_in;
   mrfp_pkg::rsp_type             rsp_ff, rsp_next;
   mrfp_pkg::cfg_type             cfg_ff;
   logic                          out_free;
   logic                          advance;
   logic                          req_accept;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reply_address    <= mrfp_pkg::RST_REPLY_ADDRESS;
         cfg_ff.module_address   <= mrfp_pkg::RST_MODULE_ADDRESS;
         cfg_ff.ok_status        <= mrfp_pkg::RST_OK_STATUS;
         cfg_ff.position_command <= mrfp_pkg::RST_POSITION_COMMAND;
      end else if (csr_write_enable) begin
         case (csr_index)
            mrfp_pkg::CSR_REPLY_ADDRESS:    cfg_ff.reply_address    <= csr_wdata;
            mrfp_pkg::CSR_MODULE_ADDRESS:   cfg_ff.module_address   <= csr_wdata;
            mrfp_pkg::CSR_OK_STATUS:        cfg_ff.ok_status        <= csr_wdata;
            mrfp_pkg::CSR_POSITION_COMMAND: cfg_ff.position_command <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   mrfp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .rsp     (rsp_next)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = rsp_ff.frame_end;
   assign rsp_tuser  = {rsp_ff.position_valid, rsp_ff.checksum_good};
   assign rsp_tdata  = {rsp_ff.position, rsp_ff.reply_command};

endmodule

// ===== src/mrfp_checker.sv =====
`timescale 1ns / 1ps

module mrfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [1:0]  rsp_tuser
);

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)
         && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   a_pos_needs_good: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast && rsp_tuser[0])
      else $error("position update without good frame end");

   a_mid_frame_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !rsp_tuser[0] && !rsp_tuser[1] && (rsp_tdata[7:0] == 8'd0))
      else $error("frame flags or command set on non-final beat");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind motor_reply_frame_parser mrfp_checker u_mrfp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/motor_reply_frame_parser_tb.sv =====
`timescale 1ns / 1ps

module motor_reply_frame_parser_tb;

   localparam int CYCLE_LIMIT = 300000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;
   logic        csr_write_enable = 1'b0;
   logic [mrfp_pkg::CsrIdxW-1:0] csr_index = '0;
   logic [mrfp_pkg::ByteW-1:0]   csr_wdata = '0;

   motor_reply_frame_parser u_top (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast),
      .rsp_tuser        (rsp_tuser),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parser copy used to predict each response beat
   mrfp_pkg::cfg_type          cfg;
   mrfp_pkg::parse_state_type  pstate;
   logic [3:0]                 fcount;
   logic [7:0]                 fbytes [0:8];
   logic [31:0]                cur_position;

   logic [7:0]         pending_bytes [$];
   mrfp_pkg::rsp_type  expected_rsp [$];

   int  queued_count = 0;
   int  checked_count = 0;
   int  err_count = 0;
   int  frame_ends = 0;
   int  position_updates = 0;
   int  settings_used = 1;
   int  cycle_count = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   bit  steady = 1'b0;
   bit  send_busy;
   mrfp_pkg::rsp_type got_rsp;
   mrfp_pkg::rsp_type want_rsp;

   function automatic mrfp_pkg::rsp_type parse_byte(input logic [7:0] b);
      mrfp_pkg::rsp_type r;
      logic [7:0]        sum;
      r = '0;
      sum = '0;
      case (pstate)
         mrfp_pkg::ST_WAIT_ADDR: begin
            fcount = '0;
            if (b == cfg.reply_address) begin
               fbytes[0] = b;
               fcount = 4'd1;
               pstate = mrfp_pkg::ST_WAIT_MOD;
            end
         end
         mrfp_pkg::ST_WAIT_MOD: begin
            if (b == cfg.module_address) begin
               fbytes[1] = b;
               fcount = 4'd2;
               pstate = mrfp_pkg::ST_WAIT_STATUS;
            end else begin
               pstate = mrfp_pkg::ST_WAIT_ADDR;
            end
         end
         mrfp_pkg::ST_WAIT_STATUS: begin
            if (b == cfg.ok_status) begin
               fbytes[2] = b;
               fcount = 4'd3;
               pstate = mrfp_pkg::ST_COLLECT;
            end else begin
               pstate = mrfp_pkg::ST_WAIT_ADDR;
            end
         end
         mrfp_pkg::ST_COLLECT: begin
            fbytes[fcount[2:0]] = b;
            fcount = fcount + 4'd1;
            if (fcount >= mrfp_pkg::SUM_LEN) pstate = mrfp_pkg::ST_CHECKSUM;
         end
         mrfp_pkg::ST_CHECKSUM: begin
            fbytes[8] = b;
            for (int i = 0; i < 8; i++) sum = sum + fbytes[i];
            r.frame_end = 1'b1;
            r.reply_command = fbytes[3];
            if (b == sum) begin
               r.checksum_good = 1'b1;
               if (fbytes[3] == cfg.position_command) begin
                  cur_position = {fbytes[4], fbytes[5], fbytes[6], fbytes[7]};
                  r.position_valid = 1'b1;
               end
            end
            fcount = '0;
            pstate = mrfp_pkg::ST_WAIT_ADDR;
         end
         default: begin
            fcount = '0;
            pstate = mrfp_pkg::ST_WAIT_ADDR;
         end
      endcase
      r.position = cur_position;
      return r;
   endfunction

   function automatic int draw_gap();
      if (steady || $urandom_range(0, 1) == 0) return 0;
      return $urandom_range(0, 14);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%t mismatch at beat %0d: %s got 0x%0h expected 0x%0h",
               $realtime, checked_count, what, got, want);
      err_count++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         send_busy = req_tvalid;
         if (req_tvalid && req_tready) begin
            expected_rsp.push_back(parse_byte(req_tdata));
            send_busy = 1'b0;
            send_gap = draw_gap();
         end
         if (!send_busy) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_bytes.size() > 0) begin
               req_tdata <= pending_bytes.pop_front();
               send_busy = 1'b1;
            end
         end
         req_tvalid <= send_busy;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_rsp.frame_end = rsp_tlast;
            got_rsp.checksum_good = rsp_tuser[0];
            got_rsp.position_valid = rsp_tuser[1];
            got_rsp.reply_command = rsp_tdata[7:0];
            got_rsp.position = rsp_tdata[39:8];
            if (expected_rsp.size() == 0) begin
               report_mismatch("beat with nothing expected", rsp_tdata[31:0], '0);
            end else begin
               want_rsp = expected_rsp.pop_front();
               if (got_rsp.frame_end !== want_rsp.frame_end)
                  report_mismatch("frame_end", got_rsp.frame_end, want_rsp.frame_end);
               if (got_rsp.checksum_good !== want_rsp.checksum_good)
                  report_mismatch("checksum_good", got_rsp.checksum_good,
                                  want_rsp.checksum_good);
               if (got_rsp.position_valid !== want_rsp.position_valid)
                  report_mismatch("position_valid", got_rsp.position_valid,
                                  want_rsp.position_valid);
               if (got_rsp.reply_command !== want_rsp.reply_command)
                  report_mismatch("reply_command", got_rsp.reply_command,
                                  want_rsp.reply_command);
               if (got_rsp.position !== want_rsp.position)
                  report_mismatch("position", got_rsp.position, want_rsp.position);
               if (want_rsp.frame_end) frame_ends++;
               if (want_rsp.position_valid) position_updates++;
            end
            checked_count++;
            recv_gap = draw_gap();
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("motor_reply_frame_parser_tb: done, errors");
         $finish;
      end
   end

   task automatic queue_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      queued_count++;
   endtask

   task automatic queue_frame(input logic [7:0] cmd, input logic [31:0] value,
                              input logic [7:0] sum_skew);
      logic [7:0] bytes [0:7];
      logic [7:0] sum;
      sum = '0;
      bytes = '{cfg.reply_address, cfg.module_address, cfg.ok_status, cmd,
                value[31:24], value[23:16], value[15:8], value[7:0]};
      for (int i = 0; i < 8; i++) begin
         queue_byte(bytes[i]);
         sum = sum + bytes[i];
      end
      queue_byte(sum + sum_skew);
   endtask

   task automatic queue_broken_header(input int bad_at);
      logic [7:0] hdr [0:2];
      hdr = '{cfg.reply_address, cfg.module_address, cfg.ok_status};
      for (int i = 0; i < bad_at; i++) queue_byte(hdr[i]);
      queue_byte(hdr[bad_at] ^ 8'($urandom_range(1, 255)));
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return $urandom();
      endcase
   endfunction

   task automatic queue_random(input int target);
      int start;
      int pick;
      logic [7:0] cmd;
      start = queued_count;
      while (queued_count - start < target) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            cmd = $urandom_range(0, 1) ? cfg.position_command : 8'($urandom_range(0, 255));
            queue_frame(cmd, pick_value(),
                        $urandom_range(0, 4) == 0 ? 8'($urandom_range(1, 255)) : 8'h00);
         end else if (pick < 8) begin
            queue_broken_header($urandom_range(0, 2));
         end else begin
            repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic wait_drained();
      while (checked_count != queued_count) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input mrfp_pkg::csr_index_type idx, input logic [7:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         mrfp_pkg::CSR_REPLY_ADDRESS:    cfg.reply_address = value;
         mrfp_pkg::CSR_MODULE_ADDRESS:   cfg.module_address = value;
         mrfp_pkg::CSR_OK_STATUS:        cfg.ok_status = value;
         mrfp_pkg::CSR_POSITION_COMMAND: cfg.position_command = value;
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [7:0] ra, input logic [7:0] ma,
                                input logic [7:0] st, input logic [7:0] pc);
      write_reg(mrfp_pkg::CSR_REPLY_ADDRESS, ra);
      write_reg(mrfp_pkg::CSR_MODULE_ADDRESS, ma);
      write_reg(mrfp_pkg::CSR_OK_STATUS, st);
      write_reg(mrfp_pkg::CSR_POSITION_COMMAND, pc);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   initial begin
      cfg = '{mrfp_pkg::RST_REPLY_ADDRESS, mrfp_pkg::RST_MODULE_ADDRESS,
              mrfp_pkg::RST_OK_STATUS, mrfp_pkg::RST_POSITION_COMMAND};
      pstate = mrfp_pkg::ST_WAIT_ADDR;
      fcount = '0;
      cur_position = '0;
      foreach (fbytes[i]) fbytes[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: negative extreme position, bad checksum, header drops
      queue_frame(cfg.position_command, 32'h8000_0000, 8'h00);
      queue_frame(cfg.position_command, 32'h7FFF_FFFF, 8'h01);
      queue_byte(cfg.reply_address);
      queue_byte(cfg.reply_address);
      queue_byte(cfg.module_address);
      queue_byte(cfg.reply_address);
      queue_byte(cfg.module_address);
      queue_byte(cfg.ok_status ^ 8'hFF);
      wait_drained();

      queue_random(90);
      wait_drained();

      apply_setting(mrfp_pkg::RST_REPLY_ADDRESS, mrfp_pkg::RST_MODULE_ADDRESS,
                    mrfp_pkg::RST_OK_STATUS, mrfp_pkg::RST_POSITION_COMMAND);
      steady = 1'b1;
      queue_random(90);
      wait_drained();

      steady = 1'b0;
      apply_setting(8'h00, 8'h00, 8'h00, 8'h00);
      queue_random(90);
      wait_drained();

      apply_setting(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      queue_random(90);
      wait_drained();

      apply_setting(8'h5A, 8'h5A, 8'h5A, 8'h5A);
      steady = 1'b1;
      queue_random(60);
      wait_drained();

      steady = 1'b0;
      repeat (2) begin
         apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         queue_random(90);
         wait_drained();
      end

      repeat (10) @(posedge clock);
      while (expected_rsp.size() > 0) begin
         want_rsp = expected_rsp.pop_front();
         report_mismatch("beat never arrived", '0, want_rsp.reply_command);
      end
      $display("sent %0d bytes over %0d register settings", queued_count, settings_used);
      $display("saw %0d frame ends and %0d position updates", frame_ends,
               position_updates);
      if (err_count == 0) begin
         $display("motor_reply_frame_parser_tb: done, clean");
      end else begin
         $display("motor_reply_frame_parser_tb: done, errors");
      end
      $finish;
   end

endmodule
